>>> src/sfwd_pkg.sv
// Shared types and constants for the SYN flood window detector.
// No dependencies.
`default_nettype none
package sfwd_pkg;
   localparam int unsigned TS_W = 48;
   localparam int unsigned CUT_W = 49;
   localparam int unsigned THR_W = 7;
   localparam int unsigned WIN_W = 16;
   localparam int unsigned CNT_OUT_W = 8;
   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam int unsigned SYN_BIT = 1;
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic CSR_WINDOW = 1'b1;
   localparam logic [THR_W-1:0] THRESHOLD_RST = 7'd100;
   localparam logic [WIN_W-1:0] WINDOW_RST = 16'd2000;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SCAN   = 7'b0000010,
      ST_STALE  = 7'b0000100,
      ST_APPEND = 7'b0001000,
      ST_PRUNE  = 7'b0010000,
      ST_CHECK  = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   // signed compare stamp < cutoff, stamp zero-extended
   function automatic logic stamp_below(input logic [TS_W-1:0] stamp,
                                        input logic signed [CUT_W-1:0] cutoff);
      logic signed [CUT_W-1:0] s;
      s = signed'({1'b0, stamp});
      return s < cutoff;
   endfunction
endpackage
`default_nettype wire

>>> src/sfwd_ring_mem.sv
// Stamp ring storage: one write port, one registered read port.
// Depends on sfwd_pkg.
`default_nettype none
module sfwd_ring_mem #(
   parameter int unsigned DEPTH = 2048,
   parameter int unsigned AW = 11
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [sfwd_pkg::TS_W-1:0] wr_data,
   input  wire logic [AW-1:0]             rd_addr,
   output logic      [sfwd_pkg::TS_W-1:0] rd_data
);
   logic [sfwd_pkg::TS_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> src/syn_flood_window_detector_top.sv
// Top level of the SYN flood window detector: sequencer, entry table, ring memory.
// Depends on sfwd_pkg and sfwd_ring_mem.
//
// channel   ports                        handshake
// request   req_* fields                 start & !busy
// result    rsp_* fields                 rsp_valid, one cycle
// config    csr_we, csr_index, csr_data  csr_we, no wait
//
// Busy sequence: a non-SYN request passes through the scan state and reports. A SYN
// request scans all TRACKED_DESTINATIONS entries; if none matches and none is free,
// it reads and checks each entry's newest stamp in search of a stale entry. It then
// appends the stamp, drops stale stamps from the front and reports; with no stale entry it reports table_full.
// The result beat follows the last busy cycle.
// Reset is synchronous; no clearing pass is needed. The receiver cannot stall.
`default_nettype none
module syn_flood_window_detector_top #(
   parameter int unsigned TRACKED_DESTINATIONS = 16,
   parameter int unsigned WINDOW_DEPTH = 128
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [7:0]  req_protocol,
   input  wire logic [7:0]  req_flags,
   input  wire logic [31:0] req_dst_ip,
   input  wire logic [15:0] req_dport,
   input  wire logic [31:0] req_src_ip,
   input  wire logic [15:0] req_sport,
   input  wire logic [47:0] req_stamp,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data,
   output logic             rsp_valid,
   output logic             rsp_alert,
   output logic             rsp_counted,
   output logic             rsp_table_full,
   output logic [7:0]       rsp_window_count,
   output logic [31:0]      rsp_alert_dst_ip,
   output logic [15:0]      rsp_alert_dport,
   output logic [31:0]      rsp_alert_src_ip,
   output logic [15:0]      rsp_alert_sport,
   output logic [47:0]      rsp_alert_time
);
   localparam int unsigned EW = (TRACKED_DESTINATIONS > 1) ? $clog2(TRACKED_DESTINATIONS) : 1;
   localparam int unsigned PW = $clog2(WINDOW_DEPTH);
   localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned AW = EW + PW;
   localparam int unsigned TS = sfwd_pkg::TS_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
   localparam logic [EW-1:0] LAST_E = EW'(TRACKED_DESTINATIONS - 1);

   sfwd_pkg::state_type state_ff, state_in;
   logic [sfwd_pkg::THR_W-1:0] thr_ff;
   logic [sfwd_pkg::WIN_W-1:0] win_ff;

   logic          valid_ff [TRACKED_DESTINATIONS];
   logic [31:0]   addr_ff  [TRACKED_DESTINATIONS];
   logic [PW-1:0] head_ff  [TRACKED_DESTINATIONS];
   logic [CW-1:0] cnt_ff   [TRACKED_DESTINATIONS];

   logic [31:0] dip_ff, sip_ff;
   logic [15:0] dport_ff, sport_ff;
   logic [TS-1:0] ts_ff;
   logic signed [sfwd_pkg::CUT_W-1:0] cut_ff;
   logic syn_ff;

   logic [EW-1:0] idx_ff, idx_in;
   logic [EW-1:0] sel_ff, sel_in;
   logic hit_ff, hit_in, free_ff, free_in;
   logic found_ff, found_in;
   logic rd_wait_ff, rd_wait_in;
   logic [PW-1:0] hd_ff, hd_in;
   logic [CW-1:0] cn_ff, cn_in;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [TS-1:0] rd_data;

   logic [PW-1:0] tail_pos, last_pos, hd_next;

   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, CW'(a)} + {1'b0, b};
      if (s >= (CW+1)'(WINDOW_DEPTH)) s = s - (CW+1)'(WINDOW_DEPTH);
      return s[PW-1:0];
   endfunction

   // each entry owns a power-of-two slot range so {entry, pos} stays in bounds
   sfwd_ring_mem #(.DEPTH(TRACKED_DESTINATIONS * (2 ** PW)), .AW(AW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(ts_ff),
      .rd_addr(rd_addr), .rd_data(rd_data));

   assign busy = (state_ff != sfwd_pkg::ST_IDLE);

   always_comb begin
      tail_pos = wrap_add(hd_ff, (cn_ff >= DEPTH_C) ? '0 : cn_ff);
      last_pos = wrap_add(head_ff[idx_ff], cnt_ff[idx_ff] - CW'(1));
      hd_next  = wrap_add(hd_ff, CW'(1));
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff; sel_in = sel_ff; hit_in = hit_ff; free_in = free_ff;
      found_in = found_ff; rd_wait_in = 1'b0; hd_in = hd_ff; cn_in = cn_ff;
      wr_en = 1'b0;
      wr_addr = {sel_ff, tail_pos};
      rd_addr = {idx_ff, last_pos};
      unique case (state_ff)
         sfwd_pkg::ST_IDLE: begin
            idx_in = '0; hit_in = 1'b0; free_in = 1'b0; found_in = 1'b0;
            if (start) state_in = sfwd_pkg::ST_SCAN;
         end
         sfwd_pkg::ST_SCAN: begin
            if (!syn_ff) begin
               state_in = sfwd_pkg::ST_DONE;
            end else begin
               if (valid_ff[idx_ff] && addr_ff[idx_ff] == dip_ff && !hit_in) begin
                  hit_in = 1'b1; sel_in = idx_ff;
               end else if (!valid_ff[idx_ff] && !hit_ff && !free_ff) begin
                  free_in = 1'b1; sel_in = idx_ff;
               end
               if (idx_ff == LAST_E) begin
                  idx_in = '0;
                  if (hit_in || free_in) state_in = sfwd_pkg::ST_APPEND;
                  else state_in = sfwd_pkg::ST_STALE;
               end else begin
                  idx_in = idx_ff + EW'(1);
               end
            end
         end
         sfwd_pkg::ST_STALE: begin
            // for each entry: issue the newest-stamp read, then check
            if (!rd_wait_ff) begin
               rd_wait_in = 1'b1;
            end else begin
               if (cnt_ff[idx_ff] == '0 || sfwd_pkg::stamp_below(rd_data, cut_ff)) begin
                  found_in = 1'b1; sel_in = idx_ff; state_in = sfwd_pkg::ST_APPEND;
               end else if (idx_ff == LAST_E) begin
                  state_in = sfwd_pkg::ST_DONE;
               end else begin
                  idx_in = idx_ff + EW'(1);
               end
            end
         end
         sfwd_pkg::ST_APPEND: begin
            if (!rd_wait_ff) begin
               // first step: load the chosen entry's ring pointers, or clear them for a new entry
               rd_wait_in = 1'b1;
               if (hit_ff) begin
                  hd_in = head_ff[sel_ff]; cn_in = cnt_ff[sel_ff];
               end else begin
                  hd_in = '0; cn_in = '0;
               end
            end else begin
               wr_en = 1'b1;
               if (cn_ff >= DEPTH_C) hd_in = hd_next;
               else cn_in = cn_ff + CW'(1);
               state_in = sfwd_pkg::ST_PRUNE;
            end
         end
         sfwd_pkg::ST_PRUNE: begin
            rd_addr = {sel_ff, hd_ff};
            if (cn_ff == '0) begin
               state_in = sfwd_pkg::ST_CHECK;
            end else if (!rd_wait_ff) begin
               rd_wait_in = 1'b1;
            end else if (sfwd_pkg::stamp_below(rd_data, cut_ff)) begin
               hd_in = hd_next; cn_in = cn_ff - CW'(1);
            end else begin
               state_in = sfwd_pkg::ST_CHECK;
            end
         end
         sfwd_pkg::ST_CHECK: state_in = sfwd_pkg::ST_IDLE;
         sfwd_pkg::ST_DONE:  state_in = sfwd_pkg::ST_IDLE;
         default: state_in = sfwd_pkg::ST_IDLE;
      endcase
   end

   logic alert_c;
   assign alert_c = (CW > sfwd_pkg::THR_W) ? (cn_ff > CW'(thr_ff))
                                           : (sfwd_pkg::THR_W'(cn_ff) > thr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sfwd_pkg::ST_IDLE;
         thr_ff <= sfwd_pkg::THRESHOLD_RST;
         win_ff <= sfwd_pkg::WINDOW_RST;
         rsp_valid <= 1'b0;
         rd_wait_ff <= 1'b0;
         for (int i = 0; i < TRACKED_DESTINATIONS; i++) begin
            valid_ff[i] <= 1'b0; head_ff[i] <= '0; cnt_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rd_wait_ff <= rd_wait_in;
         if (csr_we) begin
            unique case (csr_index)
               sfwd_pkg::CSR_THRESHOLD: thr_ff <= csr_data[sfwd_pkg::THR_W-1:0];
               sfwd_pkg::CSR_WINDOW:    win_ff <= csr_data;
               default: ;
            endcase
         end
         rsp_valid <= (state_ff == sfwd_pkg::ST_CHECK) || (state_ff == sfwd_pkg::ST_DONE);
         if (state_ff == sfwd_pkg::ST_CHECK) begin
            valid_ff[sel_ff] <= !alert_c;
            addr_ff[sel_ff] <= dip_ff;
            head_ff[sel_ff] <= alert_c ? '0 : hd_ff;
            cnt_ff[sel_ff] <= alert_c ? '0 : cn_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; sel_ff <= sel_in; hit_ff <= hit_in; free_ff <= free_in;
      found_ff <= found_in; hd_ff <= hd_in; cn_ff <= cn_in;
      if (state_ff == sfwd_pkg::ST_IDLE && start) begin
         syn_ff <= (req_protocol == sfwd_pkg::PROTO_TCP) && req_flags[sfwd_pkg::SYN_BIT];
         dip_ff <= req_dst_ip; sip_ff <= req_src_ip;
         dport_ff <= req_dport; sport_ff <= req_sport;
         ts_ff <= req_stamp;
         cut_ff <= signed'({1'b0, req_stamp})
                   - signed'(sfwd_pkg::CUT_W'(win_ff));
      end
      rsp_alert <= 1'b0; rsp_counted <= 1'b0; rsp_table_full <= 1'b0;
      rsp_window_count <= '0;
      rsp_alert_dst_ip <= '0; rsp_alert_dport <= '0;
      rsp_alert_src_ip <= '0; rsp_alert_sport <= '0; rsp_alert_time <= '0;
      if (state_ff == sfwd_pkg::ST_DONE) begin
         rsp_table_full <= syn_ff;
      end else if (state_ff == sfwd_pkg::ST_CHECK) begin
         rsp_counted <= 1'b1;
         rsp_window_count <= (CW > 8 && cn_ff > CW'(255)) ? 8'd255 : 8'(cn_ff);
         if (alert_c) begin
            rsp_alert <= 1'b1;
            rsp_alert_dst_ip <= dip_ff; rsp_alert_dport <= dport_ff;
            rsp_alert_src_ip <= sip_ff; rsp_alert_sport <= sport_ff;
            rsp_alert_time <= ts_ff;
         end
      end
   end
endmodule
`default_nettype wire
